// ===== hw/rtl/elrc_pkg.sv =====
// Types and constants shared by the event log record chain checker.
package elrc_pkg;

   localparam int unsigned ACC_LEN_W  = 40;
   localparam int unsigned WIDE_W     = 64;
   localparam int unsigned HDR_BYTES  = 7;

   localparam logic [2:0]  HDR_LAST   = 3'd7;
   localparam logic [31:0] FIRST_LEN  = 32'h0000_0030;
   localparam logic [31:0] MIN_LEN    = 32'd8;
   localparam logic [31:0] MAGIC_LFLE = 32'h654C_664C;
   localparam logic [31:0] MAGIC_11   = 32'h1111_1111;
   localparam logic [31:0] MAGIC_22   = 32'h2222_2222;
   localparam logic [31:0] MAGIC_33   = 32'h3333_3333;
   localparam logic [31:0] MAGIC_44   = 32'h4444_4444;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ACCEPT  = 2'd1,
      ST_STOP    = 2'd2,
      ST_NOT_EVT = 2'd3
   } status_type;

   typedef struct packed {
      logic [HDR_BYTES-1:0][7:0] capture;
      logic [2:0]                hdr_idx;
      status_type                chain;
      logic                      first_done;
   } ctl_type;

   function automatic logic magic_ok(input logic [31:0] m);
      magic_ok = (m == MAGIC_LFLE) || (m == MAGIC_11) || (m == MAGIC_22) ||
                 (m == MAGIC_33) || (m == MAGIC_44);
   endfunction

endpackage

// ===== hw/rtl/event_log_record_chain_check.sv =====
// Top level of the event log record chain checker.
//
// Usage: bytes of a candidate event log file enter on the req_ channel, one
// item per byte, in file order. req_start_of_file marks the first byte of a
// new candidate and clears all chain state before that byte is taken.
// Every byte gives exactly one item on the rsp_ channel: rsp_status
// (0 consistent, 1 header accepted on this byte, 2 chain stopped, 3 not an
// event log) and rsp_accepted_length, the offset just past the last
// accepted record.
// Pipeline: an accepted item is registered in the input register, evaluated
// and then registered in the result register, which drives rsp_valid.
// Throughput is one byte per cycle while the result register is not stalled,
// set by the combinational position compare and offset add between the two registers.
// Reset: valids drop and the chain state is that of a fresh candidate, so
// a start mark on the first byte is optional.
// Stall: rsp_stall holds the result register; an empty input register still
// takes one more item, then req_stall rises until the result is taken.
module event_log_record_chain_check #(
   parameter int unsigned OFFSET_BITS = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [elrc_pkg::ACC_LEN_W-1:0] rsp_accepted_length
);

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_sof_ff;
   logic                   out_valid_ff;
   elrc_pkg::status_type   out_status_ff;
   logic [elrc_pkg::ACC_LEN_W-1:0] out_len_ff;
   logic [OFFSET_BITS-1:0] pos_ff;
   logic [OFFSET_BITS-1:0] next_ff;
   elrc_pkg::ctl_type      ctl_ff;

   logic [OFFSET_BITS-1:0] pos_in;
   logic [OFFSET_BITS-1:0] next_in;
   elrc_pkg::ctl_type      ctl_in;
   elrc_pkg::status_type   status_in;
   logic [elrc_pkg::WIDE_W-1:0] next_wide;
   logic                   advance;

   elrc_step #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_step (
      .pos_ff        (pos_ff),
      .next_ff       (next_ff),
      .ctl_ff        (ctl_ff),
      .data_byte     (in_byte_ff),
      .start_of_file (in_sof_ff),
      .pos_in        (pos_in),
      .next_in       (next_in),
      .ctl_in        (ctl_in),
      .status        (status_in)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign next_wide = elrc_pkg::WIDE_W'(next_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_sof_ff  <= req_start_of_file;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff <= status_in;
         out_len_ff    <= next_wide[elrc_pkg::ACC_LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff            <= '0;
         next_ff           <= '0;
         ctl_ff.capture    <= '0;
         ctl_ff.hdr_idx    <= '0;
         ctl_ff.chain      <= elrc_pkg::ST_OK;
         ctl_ff.first_done <= 1'b0;
      end else if (advance) begin
         pos_ff  <= pos_in;
         next_ff <= next_in;
         ctl_ff  <= ctl_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_accepted_length = out_len_ff;

endmodule

// ===== hw/rtl/elrc_step.sv =====
// Next-state and status logic for one byte of the record chain check.
module elrc_step #(
   parameter int unsigned OFFSET_BITS = 40
) (
   input  logic [OFFSET_BITS-1:0] pos_ff,
   input  logic [OFFSET_BITS-1:0] next_ff,
   input  elrc_pkg::ctl_type      ctl_ff,
   input  logic [7:0]             data_byte,
   input  logic                   start_of_file,
   output logic [OFFSET_BITS-1:0] pos_in,
   output logic [OFFSET_BITS-1:0] next_in,
   output elrc_pkg::ctl_type      ctl_in,
   output elrc_pkg::status_type   status
);

   logic [OFFSET_BITS-1:0] pos;
   logic [OFFSET_BITS-1:0] nxt;
   elrc_pkg::ctl_type      ctl;
   logic [31:0]            len;
   logic [31:0]            magic;
   logic [31:0]            addend;
   logic [OFFSET_BITS:0]   sum;
   logic                   pos_max;

   always_comb begin
      pos = start_of_file ? '0 : pos_ff;
      nxt = start_of_file ? '0 : next_ff;
      if (start_of_file) begin
         ctl            = ctl_ff;
         ctl.hdr_idx    = '0;
         ctl.chain      = elrc_pkg::ST_OK;
         ctl.first_done = 1'b0;
      end else begin
         ctl = ctl_ff;
      end

      len     = {ctl.capture[3], ctl.capture[2], ctl.capture[1], ctl.capture[0]};
      magic   = {data_byte, ctl.capture[6], ctl.capture[5], ctl.capture[4]};
      addend  = ctl.first_done ? len : elrc_pkg::FIRST_LEN;
      sum     = {1'b0, nxt} + (OFFSET_BITS+1)'(addend);
      pos_max = &pos;

      pos_in  = pos;
      next_in = nxt;
      ctl_in  = ctl;
      status  = ctl.chain;

      if (ctl.chain == elrc_pkg::ST_OK) begin
         status = elrc_pkg::ST_OK;
         if (ctl.hdr_idx != '0 || pos == nxt) begin
            if (ctl.hdr_idx == elrc_pkg::HDR_LAST) begin
               ctl_in.hdr_idx = '0;
               if (!ctl.first_done) begin
                  if (len != elrc_pkg::FIRST_LEN || magic != elrc_pkg::MAGIC_LFLE) begin
                     ctl_in.chain = elrc_pkg::ST_NOT_EVT;
                     status       = elrc_pkg::ST_NOT_EVT;
                  end else begin
                     next_in           = sum[OFFSET_BITS-1:0];
                     ctl_in.first_done = 1'b1;
                     status            = elrc_pkg::ST_ACCEPT;
                  end
               end else if (!elrc_pkg::magic_ok(magic) || len < elrc_pkg::MIN_LEN ||
                            sum[OFFSET_BITS]) begin
                  ctl_in.chain = elrc_pkg::ST_STOP;
                  status       = elrc_pkg::ST_STOP;
               end else begin
                  next_in = sum[OFFSET_BITS-1:0];
                  status  = elrc_pkg::ST_ACCEPT;
               end
            end else begin
               ctl_in.capture[ctl.hdr_idx] = data_byte;
               ctl_in.hdr_idx              = ctl.hdr_idx + 3'd1;
            end
         end
         if (pos_max && ctl_in.chain == elrc_pkg::ST_OK) begin
            ctl_in.chain = elrc_pkg::ST_STOP;
         end
      end

      if (!pos_max) begin
         pos_in = pos + OFFSET_BITS'(1);
      end
   end

endmodule

// ===== test/elrc_chain_monitor.sv =====
// Checker for the event log record chain checker: predicts each result and compares it.
`timescale 1ns / 100ps

module elrc_chain_monitor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_start_of_file,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [1:0]                     rsp_status,
   input  logic [elrc_pkg::ACC_LEN_W-1:0] rsp_accepted_length,
   output int                             fail_count,
   output int                             pending
);

   localparam logic [elrc_pkg::ACC_LEN_W-1:0] POS_LAST = '1;
   localparam logic [elrc_pkg::ACC_LEN_W-1:0] POS_ONE  = 1;

   typedef struct packed {
      elrc_pkg::status_type           status;
      logic [elrc_pkg::ACC_LEN_W-1:0] length;
   } chain_outcome_type;

   chain_outcome_type outcome_q[$];

   logic [elrc_pkg::ACC_LEN_W-1:0] byte_pos;
   logic [elrc_pkg::ACC_LEN_W-1:0] next_hdr_off;
   logic [63:0]                    hdr_bytes;
   logic [3:0]                     hdr_count;
   elrc_pkg::status_type           chain;
   logic                           first_seen;

   task automatic clear_chain();
      byte_pos     = '0;
      next_hdr_off = '0;
      hdr_bytes    = '0;
      hdr_count    = '0;
      chain        = elrc_pkg::ST_OK;
      first_seen   = 1'b0;
   endtask

   function automatic logic known_magic(input logic [31:0] m);
      case (m)
         elrc_pkg::MAGIC_LFLE, elrc_pkg::MAGIC_11, elrc_pkg::MAGIC_22,
         elrc_pkg::MAGIC_33, elrc_pkg::MAGIC_44: known_magic = 1'b1;
         default: known_magic = 1'b0;
      endcase
   endfunction

   // One byte through the chain tracker; gives the status for this byte.
   task automatic advance_chain(input logic [7:0] data, input logic sof,
                                output elrc_pkg::status_type status);
      logic [31:0] len;
      logic [31:0] magic;
      logic [2:0]  k;
      if (sof) clear_chain();
      if (chain != elrc_pkg::ST_OK) begin
         status = chain;
      end else begin
         status = elrc_pkg::ST_OK;
         if (hdr_count != '0 || byte_pos == next_hdr_off) begin
            k = hdr_count[2:0];
            if (k == 3'd0) hdr_bytes = '0;
            hdr_bytes[8*k +: 8] = data;
            if (k == elrc_pkg::HDR_LAST) begin
               hdr_count = '0;
               len       = hdr_bytes[31:0];
               magic     = hdr_bytes[63:32];
               if (!first_seen) begin
                  if (len != elrc_pkg::FIRST_LEN || magic != elrc_pkg::MAGIC_LFLE) begin
                     chain  = elrc_pkg::ST_NOT_EVT;
                     status = elrc_pkg::ST_NOT_EVT;
                  end else begin
                     next_hdr_off = next_hdr_off + {8'd0, elrc_pkg::FIRST_LEN};
                     first_seen   = 1'b1;
                     status       = elrc_pkg::ST_ACCEPT;
                  end
               end else if (!known_magic(magic) || len < elrc_pkg::MIN_LEN ||
                            {8'd0, len} > POS_LAST - next_hdr_off) begin
                  chain  = elrc_pkg::ST_STOP;
                  status = elrc_pkg::ST_STOP;
               end else begin
                  next_hdr_off = next_hdr_off + {8'd0, len};
                  status       = elrc_pkg::ST_ACCEPT;
               end
            end else begin
               hdr_count = {1'b0, k} + 4'd1;
            end
         end
         if (byte_pos == POS_LAST && chain == elrc_pkg::ST_OK) chain = elrc_pkg::ST_STOP;
      end
      if (byte_pos != POS_LAST) byte_pos = byte_pos + POS_ONE;
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
      clear_chain();
   end

   always @(posedge clock) begin : watch
      chain_outcome_type    got;
      chain_outcome_type    want;
      elrc_pkg::status_type st;
      if (reset) begin
         clear_chain();
         outcome_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.status = elrc_pkg::status_type'(rsp_status);
            got.length = rsp_accepted_length;
            if (outcome_q.size() == 0) begin
               $display("%0t: result with nothing expected, status %0d length %0d",
                        $realtime, got.status, got.length);
               fail_count = fail_count + 1;
            end else begin
               want = outcome_q.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $realtime, want.status, got.status);
                  fail_count = fail_count + 1;
               end
               if (got.length !== want.length) begin
                  $display("%0t: accepted_length mismatch, expected %0d actual %0d",
                           $realtime, want.length, got.length);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            advance_chain(req_data_byte, req_start_of_file, st);
            want.status = st;
            want.length = next_hdr_off;
            outcome_q.push_back(want);
         end
      end
      pending = outcome_q.size();
   end

endmodule

// ===== test/event_log_record_chain_check_test.sv =====
// Stimulus and verdict for the event log record chain checker.
`timescale 1ns / 100ps

module event_log_record_chain_check_test;

   localparam int ITEM_GOAL = 1450;
   localparam int LONG_HOLD = 300;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [7:0]                     req_data_byte;
   logic                           req_start_of_file;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [1:0]                     rsp_status;
   logic [elrc_pkg::ACC_LEN_W-1:0] rsp_accepted_length;
   int                             fail_count;
   int                             pending;

   int bytes_sent;
   bit tx_quiet;
   bit rx_quiet;
   bit hold_long;

   logic [31:0] magic_set [5];

   event_log_record_chain_check uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_start_of_file   (req_start_of_file),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_accepted_length (rsp_accepted_length)
   );

   elrc_chain_monitor monitor (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_start_of_file   (req_start_of_file),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_accepted_length (rsp_accepted_length),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("event_log_record_chain_check_test failed");
      $finish;
   end

   task automatic send_byte(input logic [7:0] data, input logic sof);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_start_of_file <= sof;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent = bytes_sent + 1;
   endtask

   // Length little-endian, then magic little-endian.
   task automatic send_header(input logic [31:0] len, input logic [31:0] magic,
                              input logic sof);
      for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8], sof && i == 0);
      for (int i = 0; i < 4; i++) send_byte(magic[8*i +: 8], 1'b0);
   endtask

   task automatic send_filler(input int count);
      repeat (count) send_byte(8'($urandom), 1'b0);
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
   endtask

   // A file that opens with a first record and, if its header is good, goes on with a chain of records.
   task automatic send_log_file();
      logic [31:0] len;
      logic [31:0] magic;
      int          records;
      int          pick;
      int          bit_sel;
      bit          broken;
      len   = elrc_pkg::FIRST_LEN;
      magic = elrc_pkg::MAGIC_LFLE;
      if ($urandom_range(0, 5) == 0) begin
         bit_sel = $urandom_range(0, 31);
         if ($urandom_range(0, 1)) len[bit_sel] = ~len[bit_sel];
         else magic[bit_sel] = ~magic[bit_sel];
      end
      send_header(len, magic, 1'b1);
      if (len != elrc_pkg::FIRST_LEN || magic != elrc_pkg::MAGIC_LFLE) begin
         send_filler($urandom_range(0, 4));
         return;
      end
      send_filler(int'(elrc_pkg::FIRST_LEN) - 8);
      records = $urandom_range(1, 6);
      repeat (records) begin
         broken = 1'b0;
         magic  = magic_set[$urandom_range(0, 4)];
         pick   = $urandom_range(0, 19);
         if (pick == 0) begin
            len = $urandom | 32'h8;
         end else if (pick < 3) begin
            len    = $urandom_range(0, 7);
            broken = 1'b1;
         end else begin
            len = $urandom_range(8, 24);
         end
         if ($urandom_range(0, 11) == 0) begin
            bit_sel        = $urandom_range(0, 31);
            magic[bit_sel] = ~magic[bit_sel];
            broken         = 1'b1;
         end
         send_header(len, magic, 1'b0);
         if (broken || pick == 0) begin
            send_filler($urandom_range(0, 6));
            return;
         end
         send_filler(int'(len) - 8);
      end
   endtask

   initial begin : rx_side
      int n;
      int taken;
      taken = 0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_long) begin
            hold_long = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            n = rx_quiet ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken = taken + 1;
         if (taken % 64 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
      end
   end

   initial begin : tx_side
      int file_no;
      magic_set[0] = elrc_pkg::MAGIC_LFLE;
      magic_set[1] = elrc_pkg::MAGIC_11;
      magic_set[2] = elrc_pkg::MAGIC_22;
      magic_set[3] = elrc_pkg::MAGIC_33;
      magic_set[4] = elrc_pkg::MAGIC_44;
      bytes_sent = 0;
      tx_quiet   = 1'b0;
      rx_quiet   = 1'b0;
      hold_long  = 1'b0;
      file_no    = 0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_data_byte     <= 8'h00;
      req_start_of_file <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no start mark after reset: good first header
      send_header(elrc_pkg::FIRST_LEN, elrc_pkg::MAGIC_LFLE, 1'b0);
      // wrong first length, then a byte after the reject
      send_header(elrc_pkg::FIRST_LEN + 32'd1, elrc_pkg::MAGIC_LFLE, 1'b1);
      send_byte(8'hFF, 1'b0);
      // restart in the middle of a header
      send_byte(8'h30, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_header(elrc_pkg::FIRST_LEN, elrc_pkg::MAGIC_LFLE, 1'b1);

      while (bytes_sent < ITEM_GOAL) begin
         file_no = file_no + 1;
         if (file_no == 3) hold_long = 1'b1;
         if (file_no == 6) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         if ($urandom_range(0, 7) == 0) send_noise($urandom_range(5, 30));
         else send_log_file();
         tx_quiet = ($urandom_range(0, 3) == 0);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("event_log_record_chain_check_test passed");
      end else begin
         $display("event_log_record_chain_check_test failed");
      end
      $finish;
   end

endmodule
